FILE: src/ibds_pkg.sv
// Shared types, the divider ROM and the controller states of the SCL divider search.
package ibds_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned IcrW     = 6;
  localparam int unsigned MultW    = 2;
  localparam int unsigned DivW     = 12;
  localparam int unsigned DenomW   = 14;
  localparam int unsigned RomDepth = 50;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned StepW    = 5;

  localparam logic [IdxW-1:0]  LastIdx     = IdxW'(RomDepth - 1);
  localparam logic [MultW-1:0] LastMult    = 2'd2;
  localparam logic [DataW-1:0] ErrInit     = 32'hffff_ffff;
  localparam logic [DataW-1:0] ResetBusClk = 32'd50_000_000;

  typedef struct packed {
    logic [IcrW-1:0] icr;
    logic [DivW-1:0] divider;
  } rom_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_DIV,
    ST_CMP,
    ST_RESP
  } state_e;

  function automatic rom_entry_t rom_entry(input logic [IdxW-1:0] idx);
    rom_entry_t e;
    case (idx)
      6'd0:  e = '{6'h00, 12'd20};
      6'd1:  e = '{6'h01, 12'd22};
      6'd2:  e = '{6'h02, 12'd24};
      6'd3:  e = '{6'h03, 12'd26};
      6'd4:  e = '{6'h04, 12'd28};
      6'd5:  e = '{6'h05, 12'd30};
      6'd6:  e = '{6'h09, 12'd32};
      6'd7:  e = '{6'h06, 12'd34};
      6'd8:  e = '{6'h0a, 12'd36};
      6'd9:  e = '{6'h07, 12'd40};
      6'd10: e = '{6'h0c, 12'd44};
      6'd11: e = '{6'h0d, 12'd48};
      6'd12: e = '{6'h0e, 12'd56};
      6'd13: e = '{6'h12, 12'd64};
      6'd14: e = '{6'h0f, 12'd68};
      6'd15: e = '{6'h13, 12'd72};
      6'd16: e = '{6'h14, 12'd80};
      6'd17: e = '{6'h15, 12'd88};
      6'd18: e = '{6'h19, 12'd96};
      6'd19: e = '{6'h16, 12'd104};
      6'd20: e = '{6'h1a, 12'd112};
      6'd21: e = '{6'h17, 12'd128};
      6'd22: e = '{6'h1c, 12'd144};
      6'd23: e = '{6'h1d, 12'd160};
      6'd24: e = '{6'h1e, 12'd192};
      6'd25: e = '{6'h22, 12'd224};
      6'd26: e = '{6'h1f, 12'd240};
      6'd27: e = '{6'h23, 12'd256};
      6'd28: e = '{6'h24, 12'd288};
      6'd29: e = '{6'h25, 12'd320};
      6'd30: e = '{6'h26, 12'd384};
      6'd31: e = '{6'h2a, 12'd448};
      6'd32: e = '{6'h27, 12'd480};
      6'd33: e = '{6'h2b, 12'd512};
      6'd34: e = '{6'h2c, 12'd576};
      6'd35: e = '{6'h2d, 12'd640};
      6'd36: e = '{6'h2e, 12'd768};
      6'd37: e = '{6'h32, 12'd896};
      6'd38: e = '{6'h2f, 12'd960};
      6'd39: e = '{6'h33, 12'd1024};
      6'd40: e = '{6'h34, 12'd1152};
      6'd41: e = '{6'h35, 12'd1280};
      6'd42: e = '{6'h36, 12'd1536};
      6'd43: e = '{6'h3a, 12'd1792};
      6'd44: e = '{6'h37, 12'd1920};
      6'd45: e = '{6'h3b, 12'd2048};
      6'd46: e = '{6'h3c, 12'd2304};
      6'd47: e = '{6'h3d, 12'd2560};
      6'd48: e = '{6'h3e, 12'd3072};
      6'd49: e = '{6'h3f, 12'd3840};
      default: e = '{6'h00, 12'd20};
    endcase
    return e;
  endfunction

endpackage

FILE: src/i2c_baud_divider_search.sv
// SCL divider search: finds the ICR/MULT pair whose rate lies closest to a request.
//
// Usage: write the bus clock in hertz on the cfg channel (cfg_valid_i / cfg_ready_o /
// cfg_data_i) while idle with start low; it resets to 50 MHz. Pulse start with the
// requested SCL rate on target_baud_i while busy is low; that edge is the transfer.
// busy stays high until the result has been shown. The result appears on
// rejected_o, icr_code_o, mult_code_o and rate_error_o for exactly one cycle,
// marked by result_valid_o; the receiver takes it then and cannot hold it off.
//
// A request above clock/20 is rejected and answered in the cycle after the
// transfer. Otherwise each of up to 150 candidates takes a ROM read, an operand
// load, a bit-serial restoring divide and a compare, and an exact match ends the
// search early. One request is handled at a time, and the next transfer can come
// in the cycle after the result.
//
// Reset returns to idle, drops any search in flight and restores the bus clock.
module i2c_baud_divider_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ibds_pkg::DataW-1:0]        cfg_data_i,
  input  logic                              start,
  output logic                              busy,
  input  logic [ibds_pkg::DataW-1:0]        target_baud_i,
  output logic                              result_valid_o,
  output logic                              rejected_o,
  output logic [ibds_pkg::IcrW-1:0]         icr_code_o,
  output logic [ibds_pkg::MultW-1:0]        mult_code_o,
  output logic [ibds_pkg::DataW-1:0]        rate_error_o
);

  localparam int unsigned DataW  = ibds_pkg::DataW;
  localparam int unsigned DenomW = ibds_pkg::DenomW;

  ibds_pkg::state_e state_q, state_d;

  logic [DataW-1:0]            bus_clk_q;
  logic [DataW-1:0]            target_q;
  ibds_pkg::rom_entry_t        rom_q;
  logic [ibds_pkg::IdxW-1:0]   idx_q;
  logic [ibds_pkg::MultW-1:0]  mult_q;
  logic [ibds_pkg::StepW-1:0]  step_q;
  logic [DenomW-1:0]           denom_q;
  logic [DenomW-1:0]           rem_q;
  logic [DataW-1:0]            quo_q;
  logic [DataW-1:0]            best_err_q;
  logic [ibds_pkg::IcrW-1:0]   best_icr_q;
  logic [ibds_pkg::MultW-1:0]  best_mult_q;
  logic                        rejected_q;

  logic                        accept;
  logic [DataW+4:0]            target_x20;
  logic                        too_fast;
  logic [DenomW:0]             rem_sh;
  logic                        sub_ok;
  logic [DataW-1:0]            err;
  logic                        better;
  logic                        last_cand;

  assign accept     = start && !busy;
  // target > clk/20 exactly when 20*target > clk
  assign target_x20 = ({5'd0, target_baud_i} << 4) + ({5'd0, target_baud_i} << 2);
  assign too_fast   = target_x20 > {5'd0, bus_clk_q};

  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign sub_ok = rem_sh >= {1'b0, denom_q};

  assign err       = (target_q > quo_q) ? (target_q - quo_q) : (quo_q - target_q);
  assign better    = err < best_err_q;
  assign last_cand = (idx_q == ibds_pkg::LastIdx) && (mult_q == ibds_pkg::LastMult);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ibds_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = too_fast ? ibds_pkg::ST_RESP : ibds_pkg::ST_FETCH;
        end
      end
      ibds_pkg::ST_FETCH: state_d = ibds_pkg::ST_LOAD;
      ibds_pkg::ST_LOAD:  state_d = ibds_pkg::ST_DIV;
      ibds_pkg::ST_DIV: begin
        if (step_q == '1) begin
          state_d = ibds_pkg::ST_CMP;
        end
      end
      ibds_pkg::ST_CMP: begin
        if ((better && err == '0) || last_cand) begin
          state_d = ibds_pkg::ST_RESP;
        end else begin
          state_d = ibds_pkg::ST_FETCH;
        end
      end
      ibds_pkg::ST_RESP: state_d = ibds_pkg::ST_IDLE;
      default:           state_d = ibds_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy           = 1'b1;
    cfg_ready_o    = 1'b0;
    result_valid_o = 1'b0;
    case (state_q)
      ibds_pkg::ST_IDLE: begin
        busy        = 1'b0;
        // hold off a clock write while a request is being taken
        cfg_ready_o = !start;
      end
      ibds_pkg::ST_RESP: result_valid_o = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign rejected_o   = rejected_q;
  assign icr_code_o   = best_icr_q;
  assign mult_code_o  = best_mult_q;
  assign rate_error_o = best_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ibds_pkg::ST_IDLE;
      bus_clk_q <= ibds_pkg::ResetBusClk;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bus_clk_q <= cfg_data_i;
      end
    end
  end

  // synchronous divider ROM, registered read
  always_ff @(posedge clk_i) begin
    rom_q <= ibds_pkg::rom_entry(idx_q);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ibds_pkg::ST_IDLE: begin
        if (accept) begin
          target_q   <= target_baud_i;
          idx_q      <= '0;
          mult_q     <= '0;
          rejected_q <= too_fast;
          best_icr_q <= '0;
          best_mult_q <= '0;
          best_err_q <= too_fast ? '0 : ibds_pkg::ErrInit;
        end
      end
      ibds_pkg::ST_LOAD: begin
        denom_q <= DenomW'({2'b00, rom_q.divider} << mult_q);
        rem_q   <= '0;
        quo_q   <= bus_clk_q;
        step_q  <= '0;
      end
      ibds_pkg::ST_DIV: begin
        // one restoring step: shift in the next dividend bit, subtract if it fits
        rem_q  <= sub_ok ? DenomW'(rem_sh - {1'b0, denom_q}) : rem_sh[DenomW-1:0];
        quo_q  <= {quo_q[DataW-2:0], sub_ok};
        step_q <= step_q + 1'b1;
      end
      ibds_pkg::ST_CMP: begin
        if (better) begin
          best_err_q  <= err;
          best_icr_q  <= rom_q.icr;
          best_mult_q <= mult_q;
        end
        if (idx_q == ibds_pkg::LastIdx) begin
          idx_q  <= '0;
          mult_q <= mult_q + 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      default: begin
        rejected_q <= rejected_q;
      end
    endcase
  end

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rejected_o) |->
      (icr_code_o == '0 && mult_code_o == '0 && rate_error_o == '0))
    else $error("rejected result carries a setting");

  a_mult_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (mult_code_o != 2'd3))
    else $error("multiplier code out of range");

  a_cfg_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy)
    else $error("config accepted while searching");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the SCL divider search: directed and random rate requests over several bus clocks.
module tb;

  localparam int unsigned DataW = ibds_pkg::DataW;
  localparam int unsigned IcrW  = ibds_pkg::IcrW;
  localparam int unsigned MultW = ibds_pkg::MultW;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned DrainCycles  = 5300;
  localparam int unsigned DivEntries   = 50;
  localparam int unsigned TopMultCode  = 2;
  localparam int unsigned MinDivider   = 20;
  localparam logic [DataW-1:0] ResetClockHz = 32'd50_000_000;

  typedef struct packed {
    logic             rejected;
    logic [IcrW-1:0]  icr;
    logic [MultW-1:0] mult;
    logic [DataW-1:0] err;
  } scl_setting_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [DataW-1:0] cfg_data_i;
  logic             start;
  logic             busy;
  logic [DataW-1:0] target_baud_i;
  logic             result_valid_o;
  logic             rejected_o;
  logic [IcrW-1:0]  icr_code_o;
  logic [MultW-1:0] mult_code_o;
  logic [DataW-1:0] rate_error_o;

  scl_setting_t     pending_settings[$];
  logic [DataW-1:0] bus_clock_hz;
  int unsigned      fail_count;
  int unsigned      cycle_count;
  int unsigned      idle_pct;

  i2c_baud_divider_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .target_baud_i  (target_baud_i),
    .result_valid_o (result_valid_o),
    .rejected_o     (rejected_o),
    .icr_code_o     (icr_code_o),
    .mult_code_o    (mult_code_o),
    .rate_error_o   (rate_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ICR code in the upper six bits, SCL divider in the lower twelve
  function automatic logic [17:0] scl_div_entry(input int unsigned idx);
    case (idx)
      0:  return {6'h00, 12'd20};
      1:  return {6'h01, 12'd22};
      2:  return {6'h02, 12'd24};
      3:  return {6'h03, 12'd26};
      4:  return {6'h04, 12'd28};
      5:  return {6'h05, 12'd30};
      6:  return {6'h09, 12'd32};
      7:  return {6'h06, 12'd34};
      8:  return {6'h0a, 12'd36};
      9:  return {6'h07, 12'd40};
      10: return {6'h0c, 12'd44};
      11: return {6'h0d, 12'd48};
      12: return {6'h0e, 12'd56};
      13: return {6'h12, 12'd64};
      14: return {6'h0f, 12'd68};
      15: return {6'h13, 12'd72};
      16: return {6'h14, 12'd80};
      17: return {6'h15, 12'd88};
      18: return {6'h19, 12'd96};
      19: return {6'h16, 12'd104};
      20: return {6'h1a, 12'd112};
      21: return {6'h17, 12'd128};
      22: return {6'h1c, 12'd144};
      23: return {6'h1d, 12'd160};
      24: return {6'h1e, 12'd192};
      25: return {6'h22, 12'd224};
      26: return {6'h1f, 12'd240};
      27: return {6'h23, 12'd256};
      28: return {6'h24, 12'd288};
      29: return {6'h25, 12'd320};
      30: return {6'h26, 12'd384};
      31: return {6'h2a, 12'd448};
      32: return {6'h27, 12'd480};
      33: return {6'h2b, 12'd512};
      34: return {6'h2c, 12'd576};
      35: return {6'h2d, 12'd640};
      36: return {6'h2e, 12'd768};
      37: return {6'h32, 12'd896};
      38: return {6'h2f, 12'd960};
      39: return {6'h33, 12'd1024};
      40: return {6'h34, 12'd1152};
      41: return {6'h35, 12'd1280};
      42: return {6'h36, 12'd1536};
      43: return {6'h3a, 12'd1792};
      44: return {6'h37, 12'd1920};
      45: return {6'h3b, 12'd2048};
      46: return {6'h3c, 12'd2304};
      47: return {6'h3d, 12'd2560};
      48: return {6'h3e, 12'd3072};
      default: return {6'h3f, 12'd3840};
    endcase
  endfunction

  function automatic scl_setting_t predict_scl_setting(input logic [DataW-1:0] baud,
                                                       input logic [DataW-1:0] clk_hz);
    scl_setting_t     best;
    logic [17:0]      entry;
    logic [DataW-1:0] denom;
    logic [DataW-1:0] rate;
    logic [DataW-1:0] err;
    best = '0;
    if (baud > clk_hz / MinDivider) begin
      best.rejected = 1'b1;
      return best;
    end
    best.err = '1;
    // first strictly better candidate wins; stop on an exact match
    for (int unsigned m = 0; m <= TopMultCode && best.err != 0; m++) begin
      for (int unsigned i = 0; i < DivEntries && best.err != 0; i++) begin
        entry = scl_div_entry(i);
        denom = DataW'(entry[11:0]) << m;
        rate  = clk_hz / denom;
        err   = (baud > rate) ? baud - rate : rate - baud;
        if (err < best.err) begin
          best.err  = err;
          best.mult = MultW'(m);
          best.icr  = entry[17:12];
        end
      end
    end
    return best;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DataW-1:0] pick_target(input logic [DataW-1:0] clk_hz);
    logic [DataW-1:0] limit;
    logic [DataW-1:0] t;
    logic [17:0]      entry;
    int unsigned      r;
    limit = clk_hz / MinDivider;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(limit + 1, 32'hffff_ffff);
    if (r < 45) begin
      // land on or near an achievable rate
      entry = scl_div_entry($urandom_range(0, DivEntries - 1));
      t = clk_hz / (DataW'(entry[11:0]) << $urandom_range(0, TopMultCode));
      t = t + $urandom_range(0, 2);
      return (t > limit) ? limit : t;
    end
    if (r < 55) return $urandom_range(0, (limit < 1000) ? limit : 1000);
    return $urandom_range(0, limit);
  endfunction

  task automatic send_request(input logic [DataW-1:0] baud);
    int unsigned gap;
    gap = pick_gap();
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    start         <= 1'b1;
    target_baud_i <= baud;
    do @(posedge clk_i); while (busy);
    pending_settings.push_back(predict_scl_setting(baud, bus_clock_hz));
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_settings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_bus_clock(input logic [DataW-1:0] hz);
    int unsigned gap;
    wait_drained();
    gap = pick_gap();
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    bus_clock_hz  = hz;
  endtask

  task automatic test_reset_clock();
    idle_pct = 50;
    send_request(32'd0);
    send_request(32'd1);
    send_request(ResetClockHz / MinDivider);
    send_request(ResetClockHz / MinDivider + 1);
    send_request(32'hffff_ffff);
    send_request(32'h7fff_ffff);
    send_request(32'd100_000);
    send_request(32'd400_000);
    // exact first at the largest divider with MULT 1, then only at the largest with MULT 2
    send_request(ResetClockHz / 7680);
    send_request(ResetClockHz / 15360);
  endtask

  task automatic test_zero_clock();
    write_bus_clock(32'd0);
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'hffff_ffff);
  endtask

  task automatic test_extreme_clocks();
    write_bus_clock(32'd20);
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'd2);
    write_bus_clock(32'hffff_ffff);
    send_request(32'hffff_ffff / MinDivider);
    send_request(32'hffff_ffff / MinDivider + 1);
    send_request(32'h8000_0000);
    send_request(32'd1);
    send_request(32'd12_345);
  endtask

  task automatic test_random_settings();
    logic [DataW-1:0] hz;
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       hz = $urandom_range(20, 4000);
        1:       hz = $urandom_range(1_000_000, 200_000_000);
        2:       hz = $urandom;
        default: hz = $urandom_range(40_000_000, 120_000_000);
      endcase
      write_bus_clock(hz);
      for (int unsigned n = 0; n < 25; n++) begin
        // switch at random between idle stretches and back-to-back stretches
        if (n % 15 == 0) idle_pct = $urandom_range(0, 1) ? 0 : 60;
        send_request(pick_target(bus_clock_hz));
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    scl_setting_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_settings.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_settings.pop_front();
        if (rejected_o !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, rejected_o);
          fail_count++;
        end
        if (icr_code_o !== want.icr) begin
          $error("icr_code: expected 0x%0h, got 0x%0h", want.icr, icr_code_o);
          fail_count++;
        end
        if (mult_code_o !== want.mult) begin
          $error("mult_code: expected %0d, got %0d", want.mult, mult_code_o);
          fail_count++;
        end
        if (rate_error_o !== want.err) begin
          $error("rate_error: expected %0d, got %0d", want.err, rate_error_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    start         = 1'b0;
    target_baud_i = '0;
    bus_clock_hz  = ResetClockHz;
    fail_count    = 0;
    cycle_count   = 0;
    idle_pct      = 50;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_clock();
    test_zero_clock();
    test_extreme_clocks();
    test_random_settings();

    wait_drained();
    // catch any stray result after the last one
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_settings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: i2c_baud_divider_search.f
src/ibds_pkg.sv
src/i2c_baud_divider_search.sv
tb/tb.sv
